@@ design/i2f_pkg.sv @@
`default_nettype none

package i2f_pkg;

   localparam int          IntWidth   = 32;
   localparam int          FloatWidth = 32;
   localparam int          CountWidth = $clog2(IntWidth);
   localparam int          ExpWidth   = 8;
   localparam int          FracWidth  = 23;
   localparam logic [ExpWidth-1:0] EXP_START = 8'd158;

   typedef struct packed {
      logic                sign;
      logic                zero;
      logic [IntWidth-1:0] mag;
   } i2f_mag_type;

   typedef struct packed {
      logic                  sign;
      logic                  zero;
      logic [IntWidth-1:0]   mag;
      logic [CountWidth-1:0] lzc;
   } i2f_count_type;

   typedef struct packed {
      logic                sign;
      logic                zero;
      logic [IntWidth-1:0] norm;
      logic [ExpWidth-1:0] expo;
   } i2f_norm_type;

   function automatic logic [CountWidth-1:0] lead_zeros(input logic [IntWidth-1:0] value);
      logic [CountWidth-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < IntWidth; i++) begin
         if (value[i]) begin
            cnt = CountWidth'(IntWidth - 1 - i);
         end
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

@@ design/i2f_if.sv @@
`default_nettype none

interface i2f_req_if import i2f_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [IntWidth-1:0] int_value;

   modport source (output valid, output int_value, input ready);
   modport sink   (input valid, input int_value, output ready);
endinterface

interface i2f_rsp_if import i2f_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FloatWidth-1:0] float_bits;

   modport source (output valid, output float_bits, input ready);
   modport sink   (input valid, input float_bits, output ready);
endinterface

`default_nettype wire

@@ design/i2f_split.sv @@
`default_nettype none

module i2f_split import i2f_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire  [IntWidth-1:0]       in_value,
   output logic                      out_valid,
   input  wire                       out_ready,
   output i2f_mag_type               out_data
);

   logic        valid_ff;
   i2f_mag_type data_ff;
   i2f_mag_type data_in;

   always_comb begin
      data_in.sign = in_value[IntWidth-1];
      data_in.zero = (in_value == '0);
      data_in.mag  = in_value[IntWidth-1] ? (~in_value + 1'b1) : in_value;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ design/i2f_count.sv @@
`default_nettype none

module i2f_count import i2f_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  wire            in_valid,
   output logic           in_ready,
   input  i2f_mag_type    in_data,
   output logic           out_valid,
   input  wire            out_ready,
   output i2f_count_type  out_data
);

   logic          valid_ff;
   i2f_count_type data_ff;
   i2f_count_type data_in;

   always_comb begin
      data_in.sign = in_data.sign;
      data_in.zero = in_data.zero;
      data_in.mag  = in_data.mag;
      data_in.lzc  = lead_zeros(in_data.mag);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ design/i2f_shift.sv @@
`default_nettype none

module i2f_shift import i2f_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  wire            in_valid,
   output logic           in_ready,
   input  i2f_count_type  in_data,
   output logic           out_valid,
   input  wire            out_ready,
   output i2f_norm_type   out_data
);

   logic         valid_ff;
   i2f_norm_type data_ff;
   i2f_norm_type data_in;

   // leading one to the top, exponent down by the shift
   always_comb begin
      data_in.sign = in_data.sign;
      data_in.zero = in_data.zero;
      data_in.norm = in_data.mag << in_data.lzc;
      data_in.expo = EXP_START - ExpWidth'(in_data.lzc);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ design/i2f_round.sv @@
`default_nettype none

module i2f_round import i2f_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  i2f_norm_type          in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output logic [FloatWidth-1:0] out_bits
);

   logic                            valid_ff;
   logic [FloatWidth-1:0]           bits_ff;
   logic [FloatWidth-1:0]           bits_in;
   logic [FracWidth-1:0]            frac;
   logic                            guard;
   logic                            sticky;
   logic                            round_up;
   logic [ExpWidth+FracWidth-1:0]   body;

   // nearest, ties to even; a carry out of the fraction bumps the exponent
   always_comb begin
      frac     = in_data.norm[IntWidth-2 -: FracWidth];
      guard    = in_data.norm[IntWidth-2-FracWidth];
      sticky   = |in_data.norm[IntWidth-3-FracWidth:0];
      round_up = guard && (sticky || frac[0]);
      body     = {in_data.expo, frac} + (ExpWidth+FracWidth)'(round_up);
      bits_in  = in_data.zero ? '0 : {in_data.sign, body};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_bits  = bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bits_ff <= bits_in;
      end
   end

endmodule

`default_nettype wire

@@ design/int32_to_float32_converter_core.sv @@
// Signed 32-bit integer to IEEE 754 single-precision converter.
//
// req_if carries one item per handshake: int_value, a two's complement
// integer. rsp_if returns one item per request: float_bits, the binary32
// pattern of the nearest single value (round to nearest, ties to even).
// Zero gives +0; the most negative integer gives exactly -2^31.
//
// Four register stages: sign/magnitude, leading-zero count, normalising
// shift, rounding. One item may enter every cycle while the receiver takes
// results, so throughput is then 1 item per cycle.
//
// Each stage holds its own valid bit and stalls only when it is full and
// the stage after it cannot take its item, so a stalled receiver fills
// bubbles before back-pressure reaches req_if.ready. Nothing is lost or
// repeated under stalls.
//
// Synchronous reset empties the pipeline; the block keeps no other state.
`default_nettype none

module int32_to_float32_converter_core import i2f_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   i2f_req_if.sink   req_if,
   i2f_rsp_if.source rsp_if
);

   logic          split_valid;
   logic          split_ready;
   i2f_mag_type   split_data;
   logic          count_valid;
   logic          count_ready;
   i2f_count_type count_data;
   logic          shift_valid;
   logic          shift_ready;
   i2f_norm_type  shift_data;

   i2f_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_value  (req_if.int_value),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   i2f_count u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (count_valid),
      .out_ready (count_ready),
      .out_data  (count_data)
   );

   i2f_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (count_valid),
      .in_ready  (count_ready),
      .in_data   (count_data),
      .out_valid (shift_valid),
      .out_ready (shift_ready),
      .out_data  (shift_data)
   );

   i2f_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shift_valid),
      .in_ready  (shift_ready),
      .in_data   (shift_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_bits  (rsp_if.float_bits)
   );

endmodule

`default_nettype wire

@@ verif/int32_to_float32_converter_core_test.sv @@
`timescale 1ns / 100ps

module int32_to_float32_converter_core_test;
   import i2f_pkg::*;

   localparam int RANDOM_ITEMS  = 1750;
   localparam int HOLD_CYCLES   = 120;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int IDLE_PCT      = 10;
   localparam int TAIL_CYCLES   = 12;

   typedef struct {
      logic signed [IntWidth-1:0] operand;
      logic [FloatWidth-1:0]      bits;
   } conversion_type;

   class binary32_scoreboard;
      conversion_type expected_q[$];
      int             mismatches;
      int             checked;
      int             noted;

      function automatic logic [FloatWidth-1:0] to_binary32(logic signed [IntWidth-1:0] v);
         logic                  neg;
         logic [IntWidth-1:0]   mag;
         logic [ExpWidth-1:0]   expo;
         logic [FracWidth-1:0]  frac;
         logic                  guard;
         logic                  sticky;
         logic [FloatWidth-1:0] packed_bits;
         if (v == 0) begin
            return '0;
         end
         neg  = v[IntWidth-1];
         mag  = neg ? IntWidth'(-v) : IntWidth'(v);
         expo = EXP_START;
         while (!mag[IntWidth-1]) begin
            mag  = mag << 1;
            expo = expo - 1'b1;
         end
         frac   = mag[IntWidth-2 -: FracWidth];
         guard  = mag[IntWidth-2-FracWidth];
         sticky = |mag[IntWidth-3-FracWidth:0];
         packed_bits = {neg, expo, frac};
         // round to nearest even; a carry runs on into the exponent
         if (guard && (sticky || frac[0])) begin
            packed_bits = packed_bits + 1'b1;
         end
         return packed_bits;
      endfunction

      function void note_operand(logic signed [IntWidth-1:0] v);
         conversion_type c;
         c.operand = v;
         c.bits    = to_binary32(v);
         expected_q.push_back(c);
         noted++;
      endfunction

      function void check_float(logic [FloatWidth-1:0] got);
         conversion_type c;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: unexpected result %h with no item pending", $realtime, got);
            end
            return;
         end
         c = expected_q.pop_front();
         checked++;
         if (got !== c.bits) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: int %0d (%h): expected %h, got %h",
                        $realtime, c.operand, c.operand, c.bits, got);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   i2f_req_if req_ch ();
   i2f_rsp_if rsp_ch ();

   int32_to_float32_converter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   binary32_scoreboard board = new();

   bit steady;
   int hold_off_req;
   int holds_done;
   int stall_cycles;
   int directed_count;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.int_value = '0;
      rsp_ch.ready     = 1'b0;
      steady       = 1'b0;
      hold_off_req = 0;
      holds_done   = 0;
      stall_cycles = 0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // monitor, scoreboard feed and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            board.note_operand(req_ch.int_value);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_float(rsp_ch.float_bits);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d pending",
                     STALL_LIMIT, board.pending());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (holds_done != hold_off_req) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task automatic offer_item(input logic signed [IntWidth-1:0] v);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            req_ch.int_value <= IntWidth'($urandom);
         end
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.int_value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [IntWidth-1:0] random_operand();
      logic [IntWidth-1:0] v;
      int                  pick;
      int                  w;
      int                  drop;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         v = $urandom;
      end else if (pick < 70) begin
         w = $urandom_range(1, IntWidth);
         v = $urandom >> (IntWidth - w);
         if ($urandom_range(0, 1)) v = -v;
      end else if (pick < 90) begin
         // halfway and near-halfway cases above the 24-bit exact range
         w    = $urandom_range(25, IntWidth - 1);
         drop = w - 24;
         v    = ($urandom | (32'd1 << (w - 1))) & ((32'd1 << w) - 1);
         v    = (v >> drop) << drop;
         v    = v | (32'd1 << (drop - 1));
         case ($urandom_range(0, 2))
            0: v = v - 1;
            1: v = v + 1;
            default: ;
         endcase
         if ($urandom_range(0, 1)) v = -v;
      end else begin
         case ($urandom_range(0, 5))
            0: v = 32'h0000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3: v = 32'h0000_0001;
            4: v = 32'hFFFF_FFFF;
            default: v = 32'h00FF_FFFF;
         endcase
      end
      return v;
   endfunction

   initial begin
      logic signed [IntWidth-1:0] directed[$];
      directed = '{
         32'sh0000_0000, 32'sh0000_0001, -32'sh1, 32'sh0000_0002,
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sh0080_0000,
         32'sh00FF_FFFF, -32'sh00FF_FFFF, 32'sh0100_0000,
         32'sh0100_0001, 32'sh0100_0003, -32'sh0100_0001, -32'sh0100_0003,
         32'sh0200_0003, 32'sh7FFF_FF80, 32'sh7FFF_FFBF, 32'sh7FFF_FFC0,
         32'sh4000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, extremes, ties, exact range and rounding carry
      foreach (directed[i]) offer_item(directed[i]);
      directed_count = directed.size();
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_off_req++;
         steady = (n >= 500 && n < 800);
         if (n == 1000) wait_for_drain();
         if (n == 1400) hold_off_req++;
         offer_item(random_operand());
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d integers (%0d directed, %0d random) across zero, extremes,",
               board.noted, directed_count, RANDOM_ITEMS);
      $display("ties and carries, with receiver hold-offs and drains; %0d checked, %0d bad",
               board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/i2f_pkg.sv
design/i2f_if.sv
design/i2f_split.sv
design/i2f_count.sv
design/i2f_shift.sv
design/i2f_round.sv
design/int32_to_float32_converter_core.sv
verif/int32_to_float32_converter_core_test.sv
